// File: sv/wsfr_pkg.sv
`default_nettype none

package wsfr_pkg;

   localparam logic [6:0] MAX_SHORT_LEN = 7'd125;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BIN    = 4'h2;
   localparam logic [3:0] OP_SHUT   = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef enum logic [5:0] {
      PH_HDR0 = 6'b000001,
      PH_HDR1 = 6'b000010,
      PH_KEY  = 6'b000100,
      PH_DATA = 6'b001000,
      PH_ECHO = 6'b010000,
      PH_SKIP = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      K_DATA  = 3'd0,
      K_EMPTY = 3'd1,
      K_PONG  = 3'd2,
      K_CLOSE = 3'd3,
      K_CUT   = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic        prev_fin;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [6:0]  payload_len;
      logic [31:0] mask_key;
      logic [6:0]  byte_index;
      logic        closed;
   } state_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic       is_text;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// File: sv/websocket_frame_receiver.sv
`default_nettype none

// channel   dir  handshake           payload
// req_      in   tvalid/tready       tdata = rx_byte, tlast = chunk_end
// rsp_      out  tvalid/tready       tdata = data_byte, tuser = {is_text, kind}, tlast = last
// csr_      in   we                  wdata = handler_attached
//
// One request per cycle unless a held result is stalled; a result is registered when its request is taken.
// Parsing runs at acceptance straight into the result register.
// req_tready drops only while a held result is stalled by rsp_tready.
// Synchronous reset clears the parser and sets handler_attached.
module websocket_frame_receiver (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_tvalid,
   output logic             req_tready,
   input  wire  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  wire  logic       req_tlast,
   output logic             rsp_tvalid,
   input  wire  logic       rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] data_byte
   output logic [3:0]       rsp_tuser,   // [2:0] kind, [3] is_text
   output logic             rsp_tlast,
   input  wire  logic       csr_we,
   input  wire  logic       csr_wdata
);

   wsfr_pkg::state_type  state_ff;
   wsfr_pkg::state_type  state_in;
   wsfr_pkg::result_type rsp_ff;
   wsfr_pkg::result_type rsp_in;
   wsfr_pkg::result_type step_res;
   logic                 handler_ff;
   logic                 handler_in;
   logic                 accept;

   assign req_tready = !rsp_ff.valid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   wsfr_step u_step (
      .state_cur        (state_ff),
      .rx_byte          (req_tdata),
      .chunk_end        (req_tlast),
      .handler_attached (handler_ff),
      .state_nxt        (state_in),
      .result           (step_res)
   );

   assign handler_in = csr_we ? csr_wdata : handler_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (accept) begin
         rsp_in = step_res;
      end else if (rsp_tready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= wsfr_pkg::PH_HDR0;
         state_ff.prev_fin     <= 1'b1;
         state_ff.frame_opcode <= 4'd0;
         state_ff.masked       <= 1'b0;
         state_ff.payload_len  <= 7'd0;
         state_ff.mask_key     <= 32'd0;
         state_ff.byte_index   <= 7'd0;
         state_ff.closed       <= 1'b0;
         rsp_ff.valid          <= 1'b0;
         handler_ff            <= 1'b1;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_ff     <= rsp_in;
         handler_ff <= handler_in;
      end
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tdata  = rsp_ff.data_byte;
   assign rsp_tuser  = {rsp_ff.is_text, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire

// File: sv/wsfr_step.sv
`default_nettype none

// next-state and result for one received byte
module wsfr_step (
   input  wire  wsfr_pkg::state_type  state_cur,
   input  wire  logic [7:0]           rx_byte,
   input  wire  logic                 chunk_end,
   input  wire  logic                 handler_attached,
   output wsfr_pkg::state_type        state_nxt,
   output wsfr_pkg::result_type       result
);

   logic       delivers;
   logic       is_text_op;
   logic       fin_byte;
   logic [7:0] key_byte;
   logic [7:0] idx_inc;

   assign is_text_op = (state_cur.frame_opcode == wsfr_pkg::OP_TEXT);
   assign delivers   = handler_attached &&
                       (is_text_op || state_cur.frame_opcode == wsfr_pkg::OP_BIN);
   assign idx_inc    = {1'b0, state_cur.byte_index} + 8'd1;
   assign fin_byte   = (idx_inc >= {1'b0, state_cur.payload_len});

   always_comb begin
      case (state_cur.byte_index[1:0])
         2'd0:    key_byte = state_cur.mask_key[7:0];
         2'd1:    key_byte = state_cur.mask_key[15:8];
         2'd2:    key_byte = state_cur.mask_key[23:16];
         default: key_byte = state_cur.mask_key[31:24];
      endcase
   end

   always_comb begin
      state_nxt        = state_cur;
      result.valid     = 1'b0;
      result.kind      = wsfr_pkg::K_CUT;
      result.data_byte = 8'd0;
      result.is_text   = 1'b0;
      result.last      = 1'b0;

      if (!state_cur.closed) begin
         case (state_cur.phase)
            wsfr_pkg::PH_HDR0: begin
               if (rx_byte[3:0] == wsfr_pkg::OP_PING) begin
                  state_nxt.phase  = wsfr_pkg::PH_ECHO;
                  result.valid     = 1'b1;
                  result.kind      = wsfr_pkg::K_PONG;
                  result.data_byte = {rx_byte[7:4], wsfr_pkg::OP_PONG};
                  result.last      = chunk_end;
               end else if (rx_byte[3:0] == wsfr_pkg::OP_SHUT) begin
                  state_nxt.closed = 1'b1;
                  result.valid     = 1'b1;
                  result.kind      = wsfr_pkg::K_CLOSE;
               end else if (!rx_byte[7] || !state_cur.prev_fin) begin
                  state_nxt.prev_fin = rx_byte[7];
                  state_nxt.phase    = wsfr_pkg::PH_SKIP;
               end else begin
                  state_nxt.prev_fin     = rx_byte[7];
                  state_nxt.frame_opcode = rx_byte[3:0];
                  state_nxt.phase        = wsfr_pkg::PH_HDR1;
                  result.valid           = chunk_end;
               end
            end
            wsfr_pkg::PH_HDR1: begin
               state_nxt.masked      = rx_byte[7];
               state_nxt.payload_len = rx_byte[6:0];
               state_nxt.byte_index  = 7'd0;
               state_nxt.mask_key    = 32'd0;
               if (rx_byte[6:0] > wsfr_pkg::MAX_SHORT_LEN) begin
                  state_nxt.phase = wsfr_pkg::PH_SKIP;
               end else if (rx_byte[7]) begin
                  state_nxt.phase = wsfr_pkg::PH_KEY;
                  result.valid    = chunk_end;
               end else if (rx_byte[6:0] == 7'd0) begin
                  state_nxt.phase = wsfr_pkg::PH_SKIP;
                  result.valid    = delivers;
                  result.kind     = wsfr_pkg::K_EMPTY;
                  result.is_text  = is_text_op;
                  result.last     = 1'b1;
               end else begin
                  state_nxt.phase = wsfr_pkg::PH_DATA;
                  result.valid    = chunk_end;
               end
            end
            wsfr_pkg::PH_KEY: begin
               case (state_cur.byte_index[1:0])
                  2'd0:    state_nxt.mask_key[7:0]   = rx_byte;
                  2'd1:    state_nxt.mask_key[15:8]  = rx_byte;
                  2'd2:    state_nxt.mask_key[23:16] = rx_byte;
                  default: state_nxt.mask_key[31:24] = rx_byte;
               endcase
               state_nxt.byte_index = idx_inc[6:0];
               result.valid         = chunk_end;
               if (state_cur.byte_index[1:0] == 2'd3) begin
                  state_nxt.byte_index = 7'd0;
                  if (state_cur.payload_len == 7'd0) begin
                     state_nxt.phase = wsfr_pkg::PH_SKIP;
                     result.valid    = delivers;
                     result.kind     = wsfr_pkg::K_EMPTY;
                     result.is_text  = is_text_op;
                     result.last     = 1'b1;
                  end else begin
                     state_nxt.phase = wsfr_pkg::PH_DATA;
                  end
               end
            end
            wsfr_pkg::PH_DATA: begin
               state_nxt.byte_index = idx_inc[6:0];
               if (fin_byte) begin
                  state_nxt.phase = wsfr_pkg::PH_SKIP;
               end
               if (chunk_end && !fin_byte) begin
                  result.valid = 1'b1;
               end else if (delivers) begin
                  result.valid     = 1'b1;
                  result.kind      = wsfr_pkg::K_DATA;
                  result.data_byte = state_cur.masked ? (rx_byte ^ key_byte) : rx_byte;
                  result.is_text   = is_text_op;
                  result.last      = fin_byte;
               end
            end
            wsfr_pkg::PH_ECHO: begin
               result.valid     = 1'b1;
               result.kind      = wsfr_pkg::K_PONG;
               result.data_byte = rx_byte;
               result.last      = chunk_end;
            end
            default: begin
            end
         endcase

         if (chunk_end && !state_nxt.closed) begin
            state_nxt.phase = wsfr_pkg::PH_HDR0;
         end
      end
   end

endmodule

`default_nettype wire
